>>> hdl/lps_pkg.sv
// Shared constants, action codes and the back-end status struct for the line stepper.
// No dependencies; imported by every module of the block but lps_fifo.
package lps_pkg;

  localparam int LPS_COORD_BITS  = 10;
  localparam int LPS_ADDR_BITS   = 20;
  localparam int LPS_ROW_W_BITS  = 11;
  localparam logic [LPS_ROW_W_BITS-1:0] LPS_ROW_W_RESET = 11'd512;

  // queue depths; the result queue needs at least 3 entries for one pixel a clock
  localparam int LPS_CMD_DEPTH = 4;
  localparam int LPS_OUT_DEPTH = 4;

  // input action codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // status from the stepping back end
  typedef struct packed {
    logic cmd_pop;
    logic out_wr;
    logic line_active;
  } lps_stat_t;

  // packed command width: 3 flags, 3 coordinates, decision, two step sizes
  function automatic int lps_cmd_bits(input int cb);
    return 6 * cb + 11;
  endfunction

endpackage

>>> hdl/lps_fifo.sv
// Small register queue, first in first out, with occupancy count.
// Depends on nothing; used for the command queue and the result queue.
module lps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             wr_ok, rd_ok;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;
  assign wr_ok = wr_en && !full;
  assign rd_ok = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_ok && !rd_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_ok && !wr_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> hdl/lps_front.sv
// Front end: classifies an input item and, for a start, works out the line set-up.
// Depends on lps_pkg; output feeds the command queue.
module lps_front
  import lps_pkg::*;
#(
  parameter int COORD_BITS = LPS_COORD_BITS
) (
  input  logic                  action,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic [lps_cmd_bits(COORD_BITS)-1:0] cmd_data
);

  localparam int CB = COORD_BITS;

  typedef struct packed {
    logic                 start;
    logic                 major_x;
    logic                 minor_inc;
    logic [CB-1:0]        x;
    logic [CB-1:0]        y;
    logic [CB-1:0]        major_end;
    logic signed [CB+2:0] decision;
    logic [CB+1:0]        step_no_move;
    logic signed [CB+2:0] step_move;
  } cmd_t;

  cmd_t                 cmd;
  logic                 x_gt, y_gt, x_eq, swap;
  logic [CB-1:0]        dx, dy, d_maj, d_min;
  logic signed [CB+2:0] dmin2, dmaj1, dmaj2;

  always_comb begin
    x_gt  = (x_start > x_end);
    y_gt  = (y_start > y_end);
    x_eq  = (x_start == x_end);
    dx    = x_gt ? (x_start - x_end) : (x_end - x_start);
    dy    = y_gt ? (y_start - y_end) : (y_end - y_start);

    cmd.start   = (action == ACT_START);
    cmd.major_x = (dx >= dy);
    // minor axis goes up for a rising or vertical line
    if (x_eq) begin
      cmd.minor_inc = 1'b1;
    end else if (!x_gt) begin
      cmd.minor_inc = (y_end > y_start);
    end else begin
      cmd.minor_inc = !(y_end > y_start);
    end

    swap  = cmd.major_x ? x_gt : y_gt;
    d_maj = cmd.major_x ? dx : dy;
    d_min = cmd.major_x ? dy : dx;

    cmd.x = swap ? x_end : x_start;
    cmd.y = swap ? y_end : y_start;
    if (cmd.major_x) begin
      cmd.major_end = swap ? x_start : x_end;
    end else begin
      cmd.major_end = swap ? y_start : y_end;
    end

    dmin2 = {2'b00, d_min, 1'b0};
    dmaj1 = {3'b000, d_maj};
    dmaj2 = {2'b00, d_maj, 1'b0};
    cmd.decision     = dmin2 - dmaj1;
    cmd.step_no_move = {1'b0, d_min, 1'b0};
    cmd.step_move    = dmin2 - dmaj2;
  end

  assign cmd_data = cmd;

endmodule

>>> hdl/lps_back.sv
// Back end: holds the line state, steps one pixel per command, forms the address.
// Depends on lps_pkg; reads the command queue and writes the result queue.
module lps_back
  import lps_pkg::*;
#(
  parameter int COORD_BITS = LPS_COORD_BITS,
  parameter int OUT_DEPTH  = LPS_OUT_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cmd_empty,
  input  logic [lps_cmd_bits(COORD_BITS)-1:0] cmd_data,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
  input  logic [LPS_ROW_W_BITS-1:0]          row_width,
  output logic                               cmd_pop,
  output logic                               out_wr,
  output logic [2*COORD_BITS+LPS_ADDR_BITS+1:0] out_data,
  output lps_stat_t                          stat
);

  localparam int CB    = COORD_BITS;
  localparam int AW    = LPS_ADDR_BITS;
  localparam int CNT_W = $clog2(OUT_DEPTH+1);

  typedef struct packed {
    logic                 start;
    logic                 major_x;
    logic                 minor_inc;
    logic [CB-1:0]        x;
    logic [CB-1:0]        y;
    logic [CB-1:0]        major_end;
    logic signed [CB+2:0] decision;
    logic [CB+1:0]        step_no_move;
    logic signed [CB+2:0] step_move;
  } cmd_t;

  cmd_t cmd;
  assign cmd = cmd_t'(cmd_data);

  // line state
  logic [CB-1:0]        cur_x_r, cur_x_nxt;
  logic [CB-1:0]        cur_y_r, cur_y_nxt;
  logic [CB-1:0]        major_end_r, major_end_nxt;
  logic signed [CB+2:0] decision_r, decision_nxt;
  logic [CB+1:0]        step_no_move_r, step_no_move_nxt;
  logic signed [CB+2:0] step_move_r, step_move_nxt;
  logic                 major_x_r, major_x_nxt;
  logic                 minor_inc_r, minor_inc_nxt;
  logic                 active_r, active_nxt;

  // pixel stage
  logic                 pix_v_r;
  logic                 pix_valid_r, pix_valid_nxt;
  logic [CB-1:0]        pix_x_r, pix_x_nxt;
  logic [CB-1:0]        pix_y_r, pix_y_nxt;
  logic                 pix_last_r, pix_last_nxt;

  logic [CNT_W:0]       in_flight;
  logic [CB-1:0]        maj, mnr, maj_inc, mnr_step, step_x, step_y;
  logic                 move;
  logic signed [CB+2:0] dec_add;
  logic [AW-1:0]        addr;

  // credit: never issue more than the result queue can still hold
  assign in_flight = (CNT_W+1)'(out_count) + (CNT_W+1)'(pix_v_r);
  assign cmd_pop   = !cmd_empty && (in_flight < (CNT_W+1)'(OUT_DEPTH));

  always_comb begin
    maj      = major_x_r ? cur_x_r : cur_y_r;
    mnr      = major_x_r ? cur_y_r : cur_x_r;
    move     = !decision_r[CB+2];
    maj_inc  = maj + 1'b1;
    if (!move) begin
      mnr_step = mnr;
    end else if (minor_inc_r) begin
      mnr_step = mnr + 1'b1;
    end else begin
      mnr_step = mnr - 1'b1;
    end
    dec_add  = move ? step_move_r : $signed({1'b0, step_no_move_r});
    step_x   = major_x_r ? maj_inc : mnr_step;
    step_y   = major_x_r ? mnr_step : maj_inc;
  end

  always_comb begin
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    major_end_nxt    = major_end_r;
    decision_nxt     = decision_r;
    step_no_move_nxt = step_no_move_r;
    step_move_nxt    = step_move_r;
    major_x_nxt      = major_x_r;
    minor_inc_nxt    = minor_inc_r;
    active_nxt       = active_r;
    pix_valid_nxt    = 1'b0;
    pix_x_nxt        = '0;
    pix_y_nxt        = '0;
    pix_last_nxt     = 1'b0;
    if (cmd_pop) begin
      if (cmd.start) begin
        cur_x_nxt        = cmd.x;
        cur_y_nxt        = cmd.y;
        major_end_nxt    = cmd.major_end;
        decision_nxt     = cmd.decision;
        step_no_move_nxt = cmd.step_no_move;
        step_move_nxt    = cmd.step_move;
        major_x_nxt      = cmd.major_x;
        minor_inc_nxt    = cmd.minor_inc;
        pix_valid_nxt    = 1'b1;
        pix_x_nxt        = cmd.x;
        pix_y_nxt        = cmd.y;
        pix_last_nxt     = ((cmd.major_x ? cmd.x : cmd.y) == cmd.major_end);
        active_nxt       = !pix_last_nxt;
      end else if (active_r) begin
        cur_x_nxt     = step_x;
        cur_y_nxt     = step_y;
        decision_nxt  = decision_r + dec_add;
        pix_valid_nxt = 1'b1;
        pix_x_nxt     = step_x;
        pix_y_nxt     = step_y;
        pix_last_nxt  = (maj_inc == major_end_r);
        active_nxt    = !pix_last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pix_v_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      pix_v_r  <= cmd_pop;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r        <= cur_x_nxt;
    cur_y_r        <= cur_y_nxt;
    major_end_r    <= major_end_nxt;
    decision_r     <= decision_nxt;
    step_no_move_r <= step_no_move_nxt;
    step_move_r    <= step_move_nxt;
    major_x_r      <= major_x_nxt;
    minor_inc_r    <= minor_inc_nxt;
    pix_valid_r    <= pix_valid_nxt;
    pix_x_r        <= pix_x_nxt;
    pix_y_r        <= pix_y_nxt;
    pix_last_r     <= pix_last_nxt;
  end

  // address wraps at the address width
  assign addr = AW'(pix_x_r) + AW'(pix_y_r) * AW'(row_width);

  assign out_wr   = pix_v_r;
  assign out_data = {pix_valid_r, pix_x_r, pix_y_r, addr, pix_last_r};

  assign stat.cmd_pop     = cmd_pop;
  assign stat.out_wr      = pix_v_r;
  assign stat.line_active = active_r;

endmodule

>>> hdl/line_pixel_stepper.sv
// Top level of the line stepper: row-width register, front end, command queue,
// stepping back end and result queue. Depends on lps_pkg, lps_fifo, lps_front, lps_back.
//
// Usage
//   Input is a queue: drive push with the item; it is taken at an edge where
//   push is high and full is low. in_action low starts a line from the two
//   endpoints, high asks for the next pixel of the current line.
//   Results come out of a queue: while empty is low the oldest pixel sits on
//   the out_ ports and pop takes it. Every input item gives exactly one result;
//   an advance with no line in progress gives out_valid_res low and zero fields.
//   Setting the pixel (value 255) at out_pixel_addr is left to the consumer.
//   cfg_wr_en writes cfg_wr_data into the row width at once; write it only
//   while both queues are drained.
// Timing
//   One item per clock sustained while the receiver keeps popping. A result
//   passes through the command queue, then the pixel stage, whose address
//   multiply feeds the result queue directly. The rate is set by the
//   combinational step of the line state (decision add and minor move).
// Reset and stalls
//   Reset (rst_n low, synchronous) empties both queues, drops any line and sets
//   the row width to 512. If the receiver stops popping, the back end stops once
//   the result queue is spoken for; the command queue then fills and raises full.

module line_pixel_stepper
  import lps_pkg::*;
#(
  parameter int COORD_BITS = LPS_COORD_BITS,
  parameter int CMD_DEPTH  = LPS_CMD_DEPTH,
  parameter int OUT_DEPTH  = LPS_OUT_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      push,
  output logic                      full,
  input  logic                      in_action,
  input  logic [COORD_BITS-1:0]     in_x_start,
  input  logic [COORD_BITS-1:0]     in_y_start,
  input  logic [COORD_BITS-1:0]     in_x_end,
  input  logic [COORD_BITS-1:0]     in_y_end,
  // result channel
  output logic                      empty,
  input  logic                      pop,
  output logic                      out_valid_res,
  output logic [COORD_BITS-1:0]     out_pixel_x,
  output logic [COORD_BITS-1:0]     out_pixel_y,
  output logic [LPS_ADDR_BITS-1:0]  out_pixel_addr,
  output logic                      out_last_pixel,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [LPS_ROW_W_BITS-1:0] cfg_wr_data
);

  localparam int CMD_W     = lps_cmd_bits(COORD_BITS);
  localparam int OUT_W     = 2 * COORD_BITS + LPS_ADDR_BITS + 2;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);

  logic [LPS_ROW_W_BITS-1:0] row_width_r;

  logic [CMD_W-1:0]          cmd_wdata, cmd_rdata;
  logic                      cmd_empty, cmd_wr;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

  logic [OUT_W-1:0]          out_wdata, out_rdata;
  logic                      out_full;
  logic [OUT_CNT_W-1:0]      out_count;

  logic                      cmd_pop, out_wr;
  lps_stat_t                 stat;

  // row width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= LPS_ROW_W_RESET;
    end else if (cfg_wr_en) begin
      row_width_r <= cfg_wr_data;
    end
  end

  lps_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .action   (in_action),
    .x_start  (in_x_start),
    .y_start  (in_y_start),
    .x_end    (in_x_end),
    .y_end    (in_y_end),
    .cmd_data (cmd_wdata)
  );

  assign cmd_wr = push && !full;

  // command queue between classification and stepping
  lps_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_wdata),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rdata),
    .full    (full),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  lps_back #(
    .COORD_BITS (COORD_BITS),
    .OUT_DEPTH  (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_rdata),
    .out_count (out_count),
    .row_width (row_width_r),
    .cmd_pop   (cmd_pop),
    .out_wr    (out_wr),
    .out_data  (out_wdata),
    .stat      (stat)
  );

  // result queue; pop transfers the head
  lps_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (out_wr),
    .wr_data (out_wdata),
    .rd_en   (pop),
    .rd_data (out_rdata),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  assign {out_valid_res, out_pixel_x, out_pixel_y, out_pixel_addr, out_last_pixel} = out_rdata;

  // credit scheme keeps the result queue from ever overflowing
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    stat.out_wr |-> !out_full)
    else $error("pixel written into a full result queue");

  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    stat.cmd_pop |-> !cmd_empty)
    else $error("back end took a command from an empty queue");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(stat.out_wr) + 32'(out_count)) <= 32'(OUT_DEPTH))
    else $error("pixels in flight exceed result queue depth");

  a_cmd_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_wr |=> (32'(cmd_count) >= 32'(1)) || $past(cmd_pop))
    else $error("command transfer lost in the queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !stat.line_active && !stat.out_wr)
    else $error("line or pixel stage live after reset");

endmodule

>>> tb/sv/line_pixel_stepper_tb.sv
// Self-checking bench for line_pixel_stepper: queue-style stimulus, a Bresenham line
// predictor and an in-order pixel checker. Depends on lps_pkg and the line_pixel_stepper RTL.
module line_pixel_stepper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lps_pkg::*;

  localparam int CB = LPS_COORD_BITS;
  localparam int AB = LPS_ADDR_BITS;
  localparam int RWB = LPS_ROW_W_BITS;
  localparam int COORD_MAX = (1 << CB) - 1;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;   // wait after the last expected pixel is popped
  localparam int MAX_REPORTS = 10;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic          action;
    logic [CB-1:0] xs;
    logic [CB-1:0] ys;
    logic [CB-1:0] xe;
    logic [CB-1:0] ye;
  } line_item_t;

  typedef struct packed {
    logic          valid;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [AB-1:0] addr;
    logic          last;
  } pixel_t;

  // DUT connections; every input starts at a known value
  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           push = 1'b0;
  logic           full;
  logic           in_action = ACT_ADVANCE;
  logic [CB-1:0]  in_x_start = '0;
  logic [CB-1:0]  in_y_start = '0;
  logic [CB-1:0]  in_x_end = '0;
  logic [CB-1:0]  in_y_end = '0;
  logic           empty;
  logic           pop = 1'b0;
  logic           out_valid_res;
  logic [CB-1:0]  out_pixel_x;
  logic [CB-1:0]  out_pixel_y;
  logic [AB-1:0]  out_pixel_addr;
  logic           out_last_pixel;
  logic           cfg_wr_en = 1'b0;
  logic [RWB-1:0] cfg_wr_data = '0;

  // bench state
  line_item_t pending_items[$];
  line_item_t cur_item;
  pixel_t     pixel_expect_q[$];
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         phase_no = 0;
  bit         hold_off = 1'b0;
  int         fail_count = 0;

  // predictor copy of the line state and the row width
  logic [RWB-1:0]       rw_shadow = LPS_ROW_W_RESET;
  logic [CB-1:0]        ln_x = '0;
  logic [CB-1:0]        ln_y = '0;
  logic [CB-1:0]        ln_major_end = '0;
  logic signed [12:0]   ln_decision = '0;
  logic [11:0]          ln_step_flat = '0;
  logic signed [12:0]   ln_step_diag = '0;
  logic                 ln_x_major = 1'b0;
  logic                 ln_minor_up = 1'b0;
  logic                 ln_active = 1'b0;

  line_pixel_stepper u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_action      (in_action),
    .in_x_start     (in_x_start),
    .in_y_start     (in_y_start),
    .in_x_end       (in_x_end),
    .in_y_end       (in_y_end),
    .empty          (empty),
    .pop            (pop),
    .out_valid_res  (out_valid_res),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_addr (out_pixel_addr),
    .out_last_pixel (out_last_pixel),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Line rasteriser prediction for one transferred item. Pushes the pixel the
  // block owes for it onto the expectation queue.
  function automatic void raster_predict(input line_item_t it);
    int         dx, dy;
    logic [31:0] addr_full;
    logic [CB-1:0] major;
    pixel_t     px;
    if (it.action == ACT_START) begin
      dx = (it.xs > it.xe) ? int'(it.xs) - int'(it.xe) : int'(it.xe) - int'(it.xs);
      dy = (it.ys > it.ye) ? int'(it.ys) - int'(it.ye) : int'(it.ye) - int'(it.ys);
      // minor direction from the quadrant; vertical lines count as rising
      if (it.xe == it.xs)     ln_minor_up = 1'b1;
      else if (it.xe > it.xs) ln_minor_up = (it.ye > it.ys);
      else                    ln_minor_up = !(it.ye > it.ys);
      if (dx >= dy) begin
        // x major, ties included; walk from the smaller x
        ln_x_major = 1'b1;
        if (it.xs > it.xe) begin
          ln_x = it.xe; ln_y = it.ye; ln_major_end = it.xs;
        end else begin
          ln_x = it.xs; ln_y = it.ys; ln_major_end = it.xe;
        end
        ln_decision  = 13'(2 * dy - dx);
        ln_step_flat = 12'(2 * dy);
        ln_step_diag = 13'(2 * (dy - dx));
      end else begin
        ln_x_major = 1'b0;
        if (it.ys > it.ye) begin
          ln_x = it.xe; ln_y = it.ye; ln_major_end = it.ys;
        end else begin
          ln_x = it.xs; ln_y = it.ys; ln_major_end = it.ye;
        end
        ln_decision  = 13'(2 * dx - dy);
        ln_step_flat = 12'(2 * dx);
        ln_step_diag = 13'(2 * (dx - dy));
      end
    end else if (!ln_active) begin
      // advance with nothing to draw: all-zero result, state untouched
      pixel_expect_q.push_back('0);
      return;
    end else begin
      if (ln_decision >= 0) begin
        if (ln_x_major) begin
          ln_x = ln_x + 1'b1;
          ln_y = ln_minor_up ? ln_y + 1'b1 : ln_y - 1'b1;
        end else begin
          ln_y = ln_y + 1'b1;
          ln_x = ln_minor_up ? ln_x + 1'b1 : ln_x - 1'b1;
        end
        ln_decision = ln_decision + ln_step_diag;
      end else begin
        if (ln_x_major) ln_x = ln_x + 1'b1;
        else            ln_y = ln_y + 1'b1;
        ln_decision = ln_decision + $signed({1'b0, ln_step_flat});
      end
    end
    major     = ln_x_major ? ln_x : ln_y;
    addr_full = 32'(ln_x) + 32'(ln_y) * 32'(rw_shadow);
    px.valid  = 1'b1;
    px.x      = ln_x;
    px.y      = ln_y;
    px.addr   = addr_full[AB-1:0];
    px.last   = (major == ln_major_end);
    ln_active = !px.last;
    pixel_expect_q.push_back(px);
  endfunction

  function automatic void compare_field(input string field, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, want, got);
    end
  endfunction

  // Sender: one item offered at a time from pending_items, held while full.
  always @(posedge clk) begin : feed_proc
    bit next_push;
    next_push = push;
    if (!rst_n) begin
      next_push = 1'b0;
    end else begin
      if (push && !full) begin
        // transfer of cur_item at this edge
        raster_predict(cur_item);
        next_push = 1'b0;
      end
      if (!next_push && pending_items.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        cur_item   = pending_items.pop_front();
        next_push  = 1'b1;
        in_action  <= cur_item.action;
        in_x_start <= cur_item.xs;
        in_y_start <= cur_item.ys;
        in_x_end   <= cur_item.xe;
        in_y_end   <= cur_item.ye;
      end
    end
    push <= next_push;
  end

  // Receiver: checks each popped pixel against the oldest expectation.
  always @(posedge clk) begin : drain_proc
    pixel_t got;
    pixel_t want;
    bit     next_pop;
    next_pop = 1'b0;
    if (rst_n) begin
      if (pop && !empty) begin
        got = '{out_valid_res, out_pixel_x, out_pixel_y, out_pixel_addr, out_last_pixel};
        if (pixel_expect_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: pixel with nothing expected, got 0x%0h", $realtime, got);
        end else begin
          want = pixel_expect_q.pop_front();
          compare_field("valid_res", want.valid, got.valid);
          compare_field("pixel_x", want.x, got.x);
          compare_field("pixel_y", want.y, got.y);
          compare_field("pixel_addr", want.addr, got.addr);
          compare_field("last_pixel", want.last, got.last);
        end
      end
      next_pop = !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
    pop <= next_pop;
  end

  // Long receiver hold-off in the pressure phase, so the block backs up and
  // raises full while the sender keeps offering.
  initial begin : hold_off_proc
    wait (phase_no == PRESSURE_PHASE);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog_proc
    #2_000_000;
    $display("line_pixel_stepper regression: fail");
    $finish;
  end

  task automatic add_start(input int xs, input int ys, input int xe, input int ye);
    line_item_t it;
    it.action = ACT_START;
    it.xs = CB'(xs);
    it.ys = CB'(ys);
    it.xe = CB'(xe);
    it.ye = CB'(ye);
    pending_items.push_back(it);
  endtask

  task automatic add_advance(input int n);
    line_item_t it;
    repeat (n) begin
      // endpoint fields are don't-care on an advance; keep them moving
      it = {ACT_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom)};
      pending_items.push_back(it);
    end
  endtask

  function automatic int pick_coord();
    int r;
    r = $urandom_range(15);
    if (r == 0) return 0;
    if (r == 1) return COORD_MAX;
    return $urandom_range(COORD_MAX);
  endfunction

  function automatic int coord_near(input int s, input int span);
    int v;
    v = s + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // Mostly complete short lines with random content, some long ones, some cut
  // short by a fresh start, and a sprinkling of stray advances and starts.
  task automatic queue_random_lines(input int n);
    int target, kind, span, steps;
    int xs, ys, xe, ye;
    target = pending_items.size() + n;
    while (pending_items.size() < target) begin
      kind = $urandom_range(99);
      xs = pick_coord();
      ys = pick_coord();
      if (kind < 85) begin
        span = (kind < 70) ? 15 : (kind < 78) ? 120 : COORD_MAX;
        xe = coord_near(xs, span);
        ye = coord_near(ys, span);
        steps = (xs > xe ? xs - xe : xe - xs);
        if ((ys > ye ? ys - ye : ye - ys) > steps) steps = (ys > ye ? ys - ye : ye - ys);
        if (kind >= 78)                 steps = $urandom_range(30);
        else if ($urandom_range(9) == 0) steps = $urandom_range(steps);
        else                            steps += $urandom_range(2);
        add_start(xs, ys, xe, ye);
        add_advance(steps);
      end else if (kind < 93) begin
        add_advance($urandom_range(1, 3));
      end else begin
        add_start(xs, ys, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
      end
    end
  endtask

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 88; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 88; end
      default:   begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  // Everything transferred and every expected pixel popped.
  task automatic drain_wait();
    do @(negedge clk);
    while (pending_items.size() != 0 || push || pixel_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_width(input logic [RWB-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    rw_shadow   = v;
  endtask

  initial begin : stim_proc
    idle_mode_t     modes[7];
    logic [RWB-1:0] widths[7];
    modes  = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_RECV, IDLE_SEND};
    // zero and 2047 lie outside the usual range; 2047 makes the address wrap
    widths = '{11'd1, 11'd1024, 11'd0, 11'd2047,
               RWB'($urandom_range(1, 1024)), RWB'($urandom_range(1, 1024)), 11'd640};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines at the reset row width
    set_idle(IDLE_NONE);
    add_advance(1);                          // advance before any line
    add_start(0, 0, 0, 0);                   // single-pixel line, last at once
    add_advance(1);                          // nothing left to draw
    add_start(0, 0, COORD_MAX, COORD_MAX);   // diagonal tie, x major
    add_advance(2);
    add_start(COORD_MAX, 0, 0, COORD_MAX);   // restart mid-line, minor falling
    add_advance(2);
    add_start(5, 0, 7, 20);                  // steep, y major rising
    add_advance(3);
    add_start(3, 10, 3, 2);                  // vertical, walked from the lower y
    add_advance(9);                          // runs to the end and one past
    add_start(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX);
    add_advance(1);
    drain_wait();

    for (int p = 0; p < 7; p++) begin
      write_row_width(widths[p]);
      @(negedge clk);
      set_idle(modes[p]);
      queue_random_lines(ITEMS_PER_PHASE);
      phase_no = p + 1;
      drain_wait();
    end

    if (fail_count == 0) begin
      $display("line_pixel_stepper regression: pass");
    end else begin
      $display("line_pixel_stepper regression: fail");
    end
    $finish;
  end

endmodule

>>> line_pixel_stepper.f
hdl/lps_pkg.sv
hdl/lps_fifo.sv
hdl/lps_front.sv
hdl/lps_back.sv
hdl/line_pixel_stepper.sv
tb/sv/line_pixel_stepper_tb.sv
